[rtl/spq_pkg.sv]
// Package for the sorted priority queue: opcodes, status codes, cell control.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned OCC_W     = 5;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[rtl/sorted_priority_queue.sv]
// Sorted priority queue top level: request decode, entry count, cell chain, output register.
// A result beat is registered and appears in the cycle after its request beat is accepted.
// Throughput: one request per cycle while the result is not stalled; every cell compares and shifts in the same cycle.
// A stalled result holds in the output register; input is taken while it drains.
// Reset (rst_ni low, async) empties the queue and drops any pending result.
// Cell contents are not reset; only slots below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // entry_value[31:0], entry_priority[63:32]
  input  wire logic [1:0]  s_axis_tuser,   // opcode[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // head_value[31:0], head_priority[63:32],
                                           // occupancy[68:64], zero[71:69]
  output logic [2:0]       m_axis_tuser    // status[1:0], queue_empty[2]
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic                     accept;
  op_e                      op;
  logic signed [DATA_W-1:0] new_val, new_pri;
  logic [CntW-1:0]          count_q, count_d;
  logic                     full, empty;
  cell_ctrl_t               ctrl;

  logic                     cell_ge  [DEPTH];
  logic signed [DATA_W-1:0] cell_val [DEPTH];
  logic signed [DATA_W-1:0] cell_pri [DEPTH];

  logic                     out_valid_q;
  status_e                  status_q, status_d;
  logic signed [DATA_W-1:0] head_val_q, head_val_d;
  logic signed [DATA_W-1:0] head_pri_q, head_pri_d;
  logic [OCC_W-1:0]         occ_q;
  logic                     empty_q;

  // request decode
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign op            = op_e'(s_axis_tuser);
  assign new_val       = s_axis_tdata[31:0];
  assign new_pri       = s_axis_tdata[63:32];

  assign full  = (count_q == CntW'(DEPTH));
  assign empty = (count_q == '0);

  assign ctrl.enq = accept && (op == OP_ENQ) && !full;
  assign ctrl.deq = accept && (op == OP_DEQ) && !empty;

  // count, status and head for this request
  always_comb begin
    count_d    = count_q;
    status_d   = ST_OK;
    head_val_d = '0;
    head_pri_d = '0;
    unique case (op)
      OP_ENQ: begin
        if (full) status_d = ST_FULL;
        else      count_d  = count_q + 1'b1;
      end
      OP_DEQ, OP_PEEK: begin
        if (empty) begin
          status_d = ST_UNDER;
        end else begin
          head_val_d = cell_val[0];
          head_pri_d = cell_pri[0];
          if (op == OP_DEQ) count_d = count_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     left_ge;
    logic signed [DATA_W-1:0] left_val, left_pri, right_val, right_pri;

    if (i == 0) begin : g_head
      assign left_ge  = 1'b1;
      assign left_val = new_val;
      assign left_pri = new_pri;
    end else begin : g_mid
      assign left_ge  = cell_ge[i-1];
      assign left_val = cell_val[i-1];
      assign left_pri = cell_pri[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_val = '0;
      assign right_pri = '0;
    end else begin : g_body
      assign right_val = cell_val[i+1];
      assign right_pri = cell_pri[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (count_q > CntW'(i)),
      .new_val_i   (new_val),
      .new_pri_i   (new_pri),
      .left_ge_i   (left_ge),
      .left_val_i  (left_val),
      .left_pri_i  (left_pri),
      .right_val_i (right_val),
      .right_pri_i (right_pri),
      .ge_o        (cell_ge[i]),
      .val_o       (cell_val[i]),
      .pri_o       (cell_pri[i])
    );
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q   <= status_d;
      head_val_q <= head_val_d;
      head_pri_q <= head_pri_d;
      occ_q      <= OCC_W'(count_d);
      empty_q    <= (count_d == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, occ_q, head_pri_q, head_val_q};
  assign m_axis_tuser  = {empty_q, status_q};

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_enq_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.enq |=> count_q == $past(count_q) + 1'b1)
    else $error("enqueue did not grow the count");

  a_deq_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.deq |=> count_q == $past(count_q) - 1'b1)
    else $error("dequeue did not shrink the count");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= CntW'(2) |-> cell_pri[0] >= cell_pri[1])
    else $error("head entry out of priority order");
`endif

endmodule
`default_nettype wire

[rtl/spq_cell.sv]
// One storage cell of the sorted chain: compares, holds, or shifts an entry.
`timescale 1ns / 1ps
`default_nettype none
module spq_cell
  import spq_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire cell_ctrl_t               ctrl_i,
  input  wire logic                     occupied_i,  // slot index below count
  input  wire logic signed [DATA_W-1:0] new_val_i,
  input  wire logic signed [DATA_W-1:0] new_pri_i,
  input  wire logic                     left_ge_i,   // left neighbor stays in place
  input  wire logic signed [DATA_W-1:0] left_val_i,
  input  wire logic signed [DATA_W-1:0] left_pri_i,
  input  wire logic signed [DATA_W-1:0] right_val_i,
  input  wire logic signed [DATA_W-1:0] right_pri_i,
  output logic                          ge_o,
  output logic signed [DATA_W-1:0]      val_o,
  output logic signed [DATA_W-1:0]      pri_o
);

  logic signed [DATA_W-1:0] val_q, val_d;
  logic signed [DATA_W-1:0] pri_q, pri_d;

  // entry stays ahead of the new one (ties keep arrival order)
  assign ge_o = occupied_i && (pri_q >= new_pri_i);

  // next entry: keep, take new, take from left, or take from right
  always_comb begin
    val_d = val_q;
    pri_d = pri_q;
    if (ctrl_i.enq && !ge_o) begin
      if (left_ge_i) begin
        val_d = new_val_i;
        pri_d = new_pri_i;
      end else begin
        val_d = left_val_i;
        pri_d = left_pri_i;
      end
    end else if (ctrl_i.deq) begin
      val_d = right_val_i;
      pri_d = right_pri_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    pri_q <= pri_d;
  end

  assign val_o = val_q;
  assign pri_o = pri_q;

endmodule
`default_nettype wire

[test/testbench.sv]
// Testbench for sorted_priority_queue: directed table, random traffic, checked by a queue predictor.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import spq_pkg::*;

  localparam int unsigned DEPTH    = DEPTH_DEF;
  localparam int unsigned N_RANDOM = 625;
  localparam int unsigned N_STEADY = 80;     // final random beats with no idling
  localparam int unsigned WD_LIMIT = 1000;   // cycles without any beat

  typedef struct packed {
    status_e            status;
    logic signed [31:0] head_val;
    logic signed [31:0] head_pri;
    logic [4:0]         occ;
    logic               empty;
  } reply_t;

  typedef struct {
    op_e         op;
    logic [31:0] val;
    logic [31:0] pri;
    bit          typed;
    reply_t      exp;
  } req_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // entry_value[31:0], entry_priority[63:32]
  logic [1:0]  s_axis_tuser;   // opcode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // head_value[31:0], head_priority[63:32], occupancy[68:64]
  logic [2:0]  m_axis_tuser;   // status[1:0], queue_empty[2]

  // Typed expectation riding along with the request beat
  logic        req_typed;
  reply_t      req_exp;

  // Predictor state
  logic signed [31:0] pq_val [DEPTH];
  logic signed [31:0] pq_pri [DEPTH];
  int unsigned        pq_count;

  reply_t     reply_q[$];
  req_row_t   table_q[$];
  int unsigned fail_count;
  int unsigned idle_cycles;
  bit          steady;

  sorted_priority_queue #(.DEPTH(DEPTH)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one request to the predicted queue and return the reply it produces
  function automatic reply_t pq_apply(op_e op, logic signed [31:0] val,
                                      logic signed [31:0] pri);
    reply_t      r;
    int unsigned pos;
    r = '{status: ST_OK, head_val: '0, head_pri: '0, occ: '0, empty: 1'b0};
    case (op)
      OP_ENQ: begin
        if (pq_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // new entry goes behind every entry of equal or higher priority
          pos = 0;
          while (pos < pq_count && pq_pri[pos] >= pri) pos++;
          for (int k = pq_count; k > pos; k--) begin
            pq_val[k] = pq_val[k-1];
            pq_pri[k] = pq_pri[k-1];
          end
          pq_val[pos] = val;
          pq_pri[pos] = pri;
          pq_count++;
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (pq_count == 0) begin
          r.status = ST_UNDER;
        end else begin
          r.head_val = pq_val[0];
          r.head_pri = pq_pri[0];
          if (op == OP_DEQ) begin
            for (int k = 0; k + 1 < pq_count; k++) begin
              pq_val[k] = pq_val[k+1];
              pq_pri[k] = pq_pri[k+1];
            end
            pq_count--;
          end
        end
      end
      default: ;
    endcase
    r.occ   = pq_count[4:0];
    r.empty = (pq_count == 0);
    return r;
  endfunction

  function automatic void add_row(op_e op, logic [31:0] val, logic [31:0] pri, bit typed,
                                  status_e st, logic [31:0] hv, logic [31:0] hp,
                                  logic [4:0] occ, logic empty);
    req_row_t row;
    row.op    = op;
    row.val   = val;
    row.pri   = pri;
    row.typed = typed;
    row.exp   = '{status: st, head_val: hv, head_pri: hp, occ: occ, empty: empty};
    table_q.push_back(row);
  endfunction

  // Predict on each request beat, check each result beat against the oldest expectation
  always @(posedge clk_i) begin
    reply_t got;
    reply_t want;
    reply_t pred;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pred = pq_apply(op_e'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[63:32]);
        reply_q.push_back(req_typed ? req_exp : pred);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.status   = status_e'(m_axis_tuser[1:0]);
        got.empty    = m_axis_tuser[2];
        got.head_val = m_axis_tdata[31:0];
        got.head_pri = m_axis_tdata[63:32];
        got.occ      = m_axis_tdata[68:64];
        if (reply_q.size() == 0) begin
          $display("%0t: result beat with nothing expected (actual %p)", $time, got);
          fail_count++;
        end else begin
          want = reply_q.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            fail_count++;
          end
          if (got.head_val !== want.head_val) begin
            $display("%0t: head_value expected %0d actual %0d", $time,
                     want.head_val, got.head_val);
            fail_count++;
          end
          if (got.head_pri !== want.head_pri) begin
            $display("%0t: head_priority expected %0d actual %0d", $time,
                     want.head_pri, got.head_pri);
            fail_count++;
          end
          if (got.occ !== want.occ) begin
            $display("%0t: occupancy expected %0d actual %0d", $time, want.occ, got.occ);
            fail_count++;
          end
          if (got.empty !== want.empty) begin
            $display("%0t: queue_empty expected %0b actual %0b", $time,
                     want.empty, got.empty);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog: cycles with no beat on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("FAIL sorted_priority_queue");
        $finish;
      end
    end
  end

  // Result side: random stall bursts until the steady tail
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!steady && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Drive one request beat, with an optional idle burst ahead of it
  task automatic send_req(op_e op, logic [31:0] val, logic [31:0] pri, bit typed,
                          reply_t exp);
    if (!steady && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pri, val};
    s_axis_tuser  <= op;
    req_typed     <= typed;
    req_exp       <= exp;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  // Random priority: mostly a narrow band for ties, some extremes, some full range
  function automatic logic [31:0] rand_pri();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return 32'($urandom_range(0, 7)) - 32'd4;
    if (sel == 5) return 32'h8000_0000;
    if (sel == 6) return 32'h7fff_ffff;
    return $urandom;
  endfunction

  initial begin
    reply_t      none;
    op_e         op;
    int unsigned roll;
    int unsigned enq_odds;
    none          = '{status: ST_OK, head_val: '0, head_pri: '0, occ: '0, empty: 1'b0};
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_NOP;
    req_typed     <= 1'b0;
    req_exp       <= none;
    steady        = 1'b0;
    fail_count    = 0;
    idle_cycles   = 0;
    pq_count      = 0;

    // Directed: empty cases, extremes, FIFO ties, fill to full, refused enqueue
    add_row(OP_PEEK, 32'h0, 32'h0, 1, ST_UNDER, 0, 0, 0, 1);
    add_row(OP_DEQ, 32'h1234_5678, 32'h8765_4321, 1, ST_UNDER, 0, 0, 0, 1);
    add_row(OP_NOP, 32'hffff_ffff, 32'hffff_ffff, 1, ST_OK, 0, 0, 0, 1);
    add_row(OP_ENQ, 32'h7fff_ffff, 32'h7fff_ffff, 1, ST_OK, 0, 0, 1, 0);
    add_row(OP_ENQ, 32'h8000_0000, 32'h8000_0000, 1, ST_OK, 0, 0, 2, 0);
    add_row(OP_PEEK, 32'h0, 32'h0, 1, ST_OK, 32'h7fff_ffff, 32'h7fff_ffff, 2, 0);
    add_row(OP_ENQ, 32'h0, 32'h7fff_ffff, 1, ST_OK, 0, 0, 3, 0);
    add_row(OP_ENQ, 32'hffff_ffff, 32'h8000_0000, 1, ST_OK, 0, 0, 4, 0);
    add_row(OP_ENQ, 32'ha5a5_a5a5, 32'h0, 1, ST_OK, 0, 0, 5, 0);
    for (int i = 0; i < 11; i++) begin
      add_row(OP_ENQ, 32'(i * 3 + 1), 32'(i % 3) - 32'd1, 0, ST_OK, 0, 0, 0, 0);
    end
    add_row(OP_ENQ, 32'h5a5a_5a5a, 32'h7fff_ffff, 1, ST_FULL, 0, 0, 16, 0);
    add_row(OP_NOP, 32'h0, 32'h0, 1, ST_OK, 0, 0, 16, 0);
    add_row(OP_DEQ, 32'h0, 32'h0, 1, ST_OK, 32'h7fff_ffff, 32'h7fff_ffff, 15, 0);
    add_row(OP_DEQ, 32'h0, 32'h0, 1, ST_OK, 32'h0, 32'h7fff_ffff, 14, 0);
    add_row(OP_PEEK, 32'h0, 32'h0, 0, ST_OK, 0, 0, 0, 0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_q[i]) begin
      send_req(table_q[i].op, table_q[i].val, table_q[i].pri, table_q[i].typed,
               table_q[i].exp);
    end

    // Random: waves that lean toward filling or draining so both ends are reached
    enq_odds = 50;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 20 == 0) enq_odds = $urandom_range(0, 2) * 30 + 20;
      if (n == N_RANDOM - N_STEADY) steady = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        op = OP_NOP;
      end else if ($urandom_range(0, 99) < enq_odds) begin
        op = OP_ENQ;
      end else if (roll < 25) begin
        op = OP_PEEK;
      end else begin
        op = OP_DEQ;
      end
      send_req(op, $urandom, rand_pri(), 0, none);
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then watch for any stray beat
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS sorted_priority_queue");
    end else begin
      $display("FAIL sorted_priority_queue");
    end
    $finish;
  end

endmodule
`default_nettype wire
